### rtl/rtsc_pkg.sv
// ----------------------------------------------------------------------------
// rtsc_pkg
// Shared types, codes and constants of the raw text tag scanner.
// ----------------------------------------------------------------------------
package rtsc_pkg;

   // text counter width
   localparam int COUNT_BITS = 16;
   localparam int LEN_BITS   = 16;
   localparam int POS_BITS   = 5;
   localparam int HELD_BITS  = 4;

   // result queue
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   // input function codes
   localparam logic [1:0] FUNC_TEXT   = 2'd0;
   localparam logic [1:0] FUNC_END    = 2'd1;
   localparam logic [1:0] FUNC_RESUME = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_TEXT   = 2'd0;
   localparam logic [1:0] KIND_INTERP = 2'd1;
   localparam logic [1:0] KIND_CLOSE  = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   // match positions
   localparam logic [POS_BITS-1:0] POS_IDLE    = 5'd0;
   localparam logic [POS_BITS-1:0] POS_AT      = 5'd1;
   localparam logic [POS_BITS-1:0] POS_LT      = 5'd2;
   localparam logic [POS_BITS-1:0] POS_SLASH   = 5'd3;
   localparam logic [POS_BITS-1:0] POS_S_UP    = 5'd4;
   localparam logic [POS_BITS-1:0] POS_S_LO    = 5'd5;
   localparam logic [POS_BITS-1:0] POS_SQ      = 5'd6;
   localparam logic [POS_BITS-1:0] POS_SQL     = 5'd7;
   localparam logic [POS_BITS-1:0] POS_ST      = 5'd8;
   localparam logic [POS_BITS-1:0] POS_STY     = 5'd9;
   localparam logic [POS_BITS-1:0] POS_STYL    = 5'd10;
   localparam logic [POS_BITS-1:0] POS_STYLE   = 5'd11;
   localparam logic [POS_BITS-1:0] POS_SC      = 5'd12;
   localparam logic [POS_BITS-1:0] POS_SCR     = 5'd13;
   localparam logic [POS_BITS-1:0] POS_SCRI    = 5'd14;
   localparam logic [POS_BITS-1:0] POS_SCRIP   = 5'd15;
   localparam logic [POS_BITS-1:0] POS_SCRIPT  = 5'd16;

   // characters
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_S_UP   = 8'h53;
   localparam logic [7:0] CH_Q_UP   = 8'h51;
   localparam logic [7:0] CH_L_UP   = 8'h4C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_A_UP   = 8'h41;
   localparam logic [7:0] CH_Z_UP   = 8'h5A;
   localparam logic [7:0] CASE_BIT  = 8'h20;

   typedef enum logic [1:0] {
      STEP_NEXT,
      STEP_FAIL,
      STEP_INTERP,
      STEP_CLOSE
   } step_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [LEN_BITS-1:0] text_length;
      logic                last;
   } result_type;

   typedef struct packed {
      logic [1:0] num;
      result_type first;
      result_type second;
   } push_type;

   // bytes held by each partial match position
   function automatic logic [HELD_BITS-1:0] held_len(input logic [POS_BITS-1:0] pos);
      logic [HELD_BITS-1:0] n;
      unique case (pos)
         POS_AT, POS_LT:                    n = 4'd1;
         POS_SLASH:                         n = 4'd2;
         POS_S_UP, POS_S_LO:                n = 4'd3;
         POS_SQ, POS_ST, POS_SC:            n = 4'd4;
         POS_SQL, POS_STY, POS_SCR:         n = 4'd5;
         POS_STYL, POS_SCRI:                n = 4'd6;
         POS_STYLE, POS_SCRIP:              n = 4'd7;
         POS_SCRIPT:                        n = 4'd8;
         default:                           n = 4'd0;
      endcase
      return n;
   endfunction

   // clamp a count to the 16-bit length field
   function automatic logic [LEN_BITS-1:0] clamp_len(input logic [COUNT_BITS-1:0] cnt);
      logic [32:0] ext;
      ext = 33'(cnt);
      return (ext > 33'((1 << LEN_BITS) - 1)) ? {LEN_BITS{1'b1}} : ext[LEN_BITS-1:0];
   endfunction

endpackage

### rtl/rtsc_scan.sv
// ----------------------------------------------------------------------------
// rtsc_scan
// Match state, text counter and result generation for one accepted byte.
// ----------------------------------------------------------------------------
module rtsc_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  logic [1:0]        item_func,
   input  logic [7:0]        item_ch,
   output rtsc_pkg::push_type push
);
   import rtsc_pkg::*;

   logic                  active_ff, active_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [7:0]            lc;
   logic                  is_term;
   step_type              step;
   logic [POS_BITS-1:0]   nx;
   logic [HELD_BITS-1:0]  held;
   logic [HELD_BITS-1:0]  add;
   logic [COUNT_BITS:0]   sum;
   logic [COUNT_BITS-1:0] sat_sum;
   logic                  start_at, start_lt;
   logic                  emit;
   logic [1:0]            emit_kind;
   logic [COUNT_BITS-1:0] emit_count;

   assign lc = (item_ch >= CH_A_UP && item_ch <= CH_Z_UP) ? (item_ch | CASE_BIT) : item_ch;
   assign is_term = (item_ch == CH_GT) || (item_ch == CH_SPACE) || (item_ch == CH_TAB) ||
                    (item_ch == CH_LF) || (item_ch == CH_CR);
   assign start_at = (item_ch == CH_AT);
   assign start_lt = (item_ch == CH_LT);
   assign held = held_len(pos_ff);

   // advance the partial match by one byte
   always_comb begin
      step = STEP_FAIL;
      nx   = POS_IDLE;
      unique case (pos_ff)
         POS_AT:     if (item_ch == CH_LBRACE) step = STEP_INTERP;
         POS_LT:     if (item_ch == CH_SLASH) begin step = STEP_NEXT; nx = POS_SLASH; end
         POS_SLASH: begin
            if (item_ch == CH_S_UP) begin
               step = STEP_NEXT; nx = POS_S_UP;
            end else if (lc == 8'h73) begin
               step = STEP_NEXT; nx = POS_S_LO;
            end
         end
         POS_S_UP, POS_S_LO: begin
            if (pos_ff == POS_S_UP && item_ch == CH_Q_UP) begin
               step = STEP_NEXT; nx = POS_SQ;
            end else if (lc == 8'h74) begin
               step = STEP_NEXT; nx = POS_ST;
            end else if (lc == 8'h63) begin
               step = STEP_NEXT; nx = POS_SC;
            end
         end
         POS_SQ:     if (item_ch == CH_L_UP) begin step = STEP_NEXT; nx = POS_SQL; end
         POS_ST:     if (lc == 8'h79) begin step = STEP_NEXT; nx = POS_STY; end
         POS_STY:    if (lc == 8'h6C) begin step = STEP_NEXT; nx = POS_STYL; end
         POS_STYL:   if (lc == 8'h65) begin step = STEP_NEXT; nx = POS_STYLE; end
         POS_SC:     if (lc == 8'h72) begin step = STEP_NEXT; nx = POS_SCR; end
         POS_SCR:    if (lc == 8'h69) begin step = STEP_NEXT; nx = POS_SCRI; end
         POS_SCRI:   if (lc == 8'h70) begin step = STEP_NEXT; nx = POS_SCRIP; end
         POS_SCRIP:  if (lc == 8'h74) begin step = STEP_NEXT; nx = POS_SCRIPT; end
         POS_SQL, POS_STYLE, POS_SCRIPT: if (is_term) step = STEP_CLOSE;
         default:    step = STEP_FAIL;
      endcase
   end

   // saturating add of held bytes plus the current byte when it is plain text
   assign add = (item_func == FUNC_END) ? held :
                (held + HELD_BITS'(!(start_at || start_lt)));
   assign sum = {1'b0, count_ff} + (COUNT_BITS + 1)'(add);
   assign sat_sum = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

   always_comb begin
      active_in  = active_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      emit       = 1'b0;
      emit_kind  = KIND_END;
      emit_count = count_ff;
      if (item_valid) begin
         if (item_func == FUNC_RESUME) begin
            active_in = 1'b1;
         end else if (active_ff && item_func == FUNC_END) begin
            emit       = 1'b1;
            emit_kind  = KIND_END;
            emit_count = sat_sum;
         end else if (active_ff && item_func == FUNC_TEXT) begin
            if (pos_ff == POS_IDLE || pos_ff > POS_SCRIPT || step == STEP_FAIL) begin
               // fold held bytes into the count, then retry this byte from idle
               count_in = sat_sum;
               pos_in   = start_at ? POS_AT : (start_lt ? POS_LT : POS_IDLE);
            end else if (step == STEP_INTERP) begin
               emit      = 1'b1;
               emit_kind = KIND_INTERP;
            end else if (step == STEP_CLOSE) begin
               emit      = 1'b1;
               emit_kind = KIND_CLOSE;
            end else begin
               pos_in = nx;
            end
         end
         if (emit) begin
            active_in = 1'b0;
            pos_in    = POS_IDLE;
            count_in  = '0;
         end
      end
   end

   always_comb begin
      push.num                = 2'd0;
      push.first.kind         = emit_kind;
      push.first.text_length  = '0;
      push.first.last         = 1'b1;
      push.second.kind        = emit_kind;
      push.second.text_length = '0;
      push.second.last        = 1'b1;
      if (emit) begin
         if (emit_count != '0) begin
            push.num               = 2'd2;
            push.first.kind        = KIND_TEXT;
            push.first.text_length = clamp_len(emit_count);
            push.first.last        = 1'b0;
         end else begin
            push.num = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         pos_ff    <= POS_IDLE;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_event_idles: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |=> !active_ff && pos_ff == POS_IDLE && count_ff == '0)
      else $error("scanner did not idle after an event");
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.num == 2'd2 |-> push.first.kind == KIND_TEXT && !push.first.last &&
                           push.second.last && push.second.kind != KIND_TEXT)
      else $error("text token and event out of order");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_SCRIPT)
      else $error("match position out of range");
`endif

endmodule

### rtl/rtsc_rsp_queue.sv
// ----------------------------------------------------------------------------
// rtsc_rsp_queue
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module rtsc_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  rtsc_pkg::push_type  push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output rtsc_pkg::result_type out_data
);
   import rtsc_pkg::*;

   result_type             slot_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ff, wr_in;
   logic [QPTR_BITS-1:0]   rd_ff, rd_in;
   logic [QCNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                   pop;
   logic [QPTR_BITS-1:0]   wr_next;

   assign out_valid = (cnt_ff != '0);
   assign out_data  = slot_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // keep space for a full pair of results
   assign room      = (cnt_ff <= QCNT_BITS'(QDEPTH - 2));
   assign wr_next   = wr_ff + QPTR_BITS'(1);

   always_comb begin
      wr_in  = wr_ff + QPTR_BITS'(push.num);
      rd_in  = rd_ff + QPTR_BITS'(pop);
      cnt_in = cnt_ff + QCNT_BITS'(push.num) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         slot_ff[wr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         slot_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> cnt_ff <= QCNT_BITS'(QDEPTH - 2))
      else $error("result queue overflow");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_BITS'(QDEPTH))
      else $error("result queue count out of range");
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |=> out_valid)
      else $error("pushed result not presented");
`endif

endmodule

### rtl/raw_text_tag_scanner_unit.sv
// ----------------------------------------------------------------------------
// raw_text_tag_scanner_unit
// Byte scanner for raw style/script bodies: text tokens, '@{' and close tags.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one byte per transfer on the req_ channel: req_tuser carries the
//   function (text byte, end of text, resume), req_tdata the byte. Each
//   transfer only advances a small match state, so one byte is taken every
//   clock cycle while the result queue has room for a pair of results.
//   When '@{', a close tag ('</style', '</script' any case, '</SQL' upper
//   case, then '>' or whitespace) or end of text is seen, the block emits an
//   optional raw text token (rsp_tuser = 0, rsp_tdata = length) and then the
//   event itself with rsp_tlast high. The scanner then ignores text and end
//   of text until a resume transfer arrives.
//   Results: a result is registered into the result queue as the byte that
//   caused it is taken and is offered on rsp_ from the queue head; the
//   second result of a pair follows the first. Stalls: a four-entry result
//   queue parts the two sides; req_tready drops only when fewer than two
//   entries are free, so rsp_tready held low does not lose or reorder anything.
//   Reset (synchronous, active high): scanning active, no partial match,
//   text count zero, result queue empty.
// ----------------------------------------------------------------------------
module raw_text_tag_scanner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] text_length
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last result of this input
);
   import rtsc_pkg::*;

   push_type   push;
   result_type head;
   logic       room;
   logic       take;

   // accept a byte whenever the queue can absorb a full result pair
   assign req_tready = room;
   assign take       = req_tvalid && req_tready;

   rtsc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .item_valid (take),
      .item_func  (req_tuser),
      .item_ch    (req_tdata),
      .push       (push)
   );

   rtsc_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   // drive the result channel from the queue head
   assign rsp_tdata = head.text_length;
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

`ifndef SYNTHESIS
   a_push_needs_take: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> take)
      else $error("result produced without an accepted transfer");
   a_text_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_TEXT |-> rsp_tdata != 16'd0 && !rsp_tlast)
      else $error("empty or final raw text token");
   a_event_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_TEXT |-> rsp_tdata == 16'd0 && rsp_tlast)
      else $error("event result carries a length");
`endif

endmodule
